>>> design/ecc_pkg.sv
package ecc_pkg;

  localparam int CMD_W   = 3;
  localparam int FLOOR_W = 2;
  localparam int TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_UP    = 3'd1,
    CMD_DOWN  = 3'd2,
    CMD_CAR   = 3'd3,
    CMD_OPEN  = 3'd4,
    CMD_CLOSE = 3'd5
  } cmd_t;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic [FLOOR_W-1:0] call_floor;
    logic [CMD_W-1:0]   cmd;
  } item_t;

  typedef struct packed {
    logic               pending;
    logic               door_open;
    logic               moving;
    logic               going_up;
    logic [FLOOR_W-1:0] car_floor;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

endpackage

>>> design/ecc_core.sv
module ecc_core #(
  parameter int NUM_FLOORS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ecc_pkg::item_t item,
  output ecc_pkg::res_t  res
);

  localparam int FW = $clog2(NUM_FLOORS);
  localparam int CW = (FW > ecc_pkg::FLOOR_W) ? FW : ecc_pkg::FLOOR_W;
  localparam logic [FW-1:0] TOP = FW'(NUM_FLOORS - 1);

  logic [NUM_FLOORS-1:0] up_calls, up_calls_next;
  logic [NUM_FLOORS-1:0] down_calls, down_calls_next;
  logic [NUM_FLOORS-1:0] car_calls, car_calls_next;
  logic [FW-1:0]         floor_reg, floor_reg_next;
  logic                  dir_up, dir_up_next;
  logic                  run_flag, run_flag_next;

  logic [NUM_FLOORS-1:0] all_calls, here, above, below, call_dec;
  logic [NUM_FLOORS-1:0] up1, dn1, car1;
  logic [CW-1:0]         cf_ext, cur_ext, floor_next_ext;
  logic                  call_ok, f_up, f_down, stop, d, step_up, step_dn;

  assign all_calls = up_calls | down_calls | car_calls;
  assign cf_ext    = CW'(item.call_floor);
  assign cur_ext   = CW'(floor_reg);
  assign call_ok   = 32'(item.call_floor) < 32'(NUM_FLOORS);
  assign f_up      = |(all_calls & above);
  assign f_down    = |(all_calls & below);

  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      here[i]     = (floor_reg == FW'(i));
      above[i]    = (FW'(i) > floor_reg);
      below[i]    = (FW'(i) < floor_reg);
      call_dec[i] = (cf_ext == CW'(i));
    end
  end

  always_comb begin
    up_calls_next   = up_calls;
    down_calls_next = down_calls;
    car_calls_next  = car_calls;
    floor_reg_next  = floor_reg;
    dir_up_next     = dir_up;
    run_flag_next   = run_flag;
    up1             = up_calls;
    dn1             = down_calls;
    car1            = car_calls;
    stop            = 1'b0;
    d               = dir_up;
    step_up         = 1'b0;
    step_dn         = 1'b0;
    unique case (ecc_pkg::cmd_t'(item.cmd))
      ecc_pkg::CMD_TICK: begin
        if (|all_calls) begin
          stop = (|(car_calls & here)) |
                 (dir_up ? ((|(up_calls & here)) | ((|(down_calls & here)) & ~f_up))
                         : ((|(down_calls & here)) | ((|(up_calls & here)) & ~f_down)));
          car1 = car_calls & ~here;
          if (dir_up) begin
            up1 = up_calls & ~here;
          end else begin
            dn1 = down_calls & ~here;
          end
          d = dir_up ? f_up : ~f_down;
          run_flag_next = 1'b1;
          if (!stop) begin
            step_up = d;
            step_dn = ~d;
          end else begin
            if (floor_reg == '0) begin
              d = 1'b1;
            end
            if (floor_reg == TOP) begin
              d = 1'b0;
            end
            // A call at this floor in the new direction is served in place.
            if (((|(up1 & here)) & d) | ((|(dn1 & here)) & ~d)) begin
              if (d) begin
                up1 = up1 & ~here;
              end else begin
                dn1 = dn1 & ~here;
              end
            end else begin
              step_up = d & f_up;
              step_dn = ~d & f_down;
            end
            if (!f_up && !f_down && !(|((up1 | dn1 | car1) & here))) begin
              run_flag_next = 1'b0;
            end
          end
          dir_up_next     = d;
          up_calls_next   = up1;
          down_calls_next = dn1;
          car_calls_next  = car1;
          if (step_up && floor_reg != TOP) begin
            floor_reg_next = floor_reg + FW'(1);
          end else if (step_dn && floor_reg != '0) begin
            floor_reg_next = floor_reg - FW'(1);
          end
        end
      end
      ecc_pkg::CMD_UP, ecc_pkg::CMD_DOWN, ecc_pkg::CMD_CAR: begin
        if (call_ok) begin
          unique case (ecc_pkg::cmd_t'(item.cmd))
            ecc_pkg::CMD_UP:   up_calls_next   = up_calls | call_dec;
            ecc_pkg::CMD_DOWN: down_calls_next = down_calls | call_dec;
            default:           car_calls_next  = car_calls | call_dec;
          endcase
          if (!(|all_calls) && !(|(call_dec & here))) begin
            dir_up_next = cf_ext > cur_ext;
          end
        end
      end
      ecc_pkg::CMD_OPEN: begin
        if (!run_flag) begin
          car_calls_next = car_calls | here;
        end
      end
      default: begin
      end
    endcase
  end

  assign floor_next_ext = CW'(floor_reg_next);
  assign res.car_floor  = floor_next_ext[ecc_pkg::FLOOR_W-1:0];
  assign res.going_up   = dir_up_next;
  assign res.moving     = run_flag_next;
  assign res.door_open  = stop;
  assign res.pending    = |(up_calls_next | down_calls_next | car_calls_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      up_calls   <= '0;
      down_calls <= '0;
      car_calls  <= '0;
      floor_reg  <= FW'(1);
      dir_up     <= 1'b1;
      run_flag   <= 1'b0;
    end else if (en) begin
      up_calls   <= up_calls_next;
      down_calls <= down_calls_next;
      car_calls  <= car_calls_next;
      floor_reg  <= floor_reg_next;
      dir_up     <= dir_up_next;
      run_flag   <= run_flag_next;
    end
  end

endmodule

>>> design/elevator_collective_controller_unit.sv
// Collective elevator controller for one car. Each input transfer carries a
// tick or a request, and each one yields exactly one result transfer with the
// car floor, direction, run flag, door flag and pending flag after that item.
// The block takes one item per clock cycle unless the result side stalls;
// an item passes through the input register and then the result register,
// and the whole state update for an item happens as it moves from the one
// to the other. Backpressure on the result side stalls both registers.
module elevator_collective_controller_unit #(
  parameter int NUM_FLOORS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // cmd [2:0], call_floor [4:3], unused [7:5]
  input  logic [7:0] s_axis_tdata,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // car_floor [1:0], going_up [2], moving [3], door_open [4], pending [5], zero [7:6]
  output logic [7:0] m_axis_tdata
);

  ecc_pkg::item_t item_q;
  ecc_pkg::res_t  res_q;
  ecc_pkg::res_t  res;
  logic           in_valid;
  logic           out_valid;
  logic           advance;
  logic           process;

  assign advance       = !out_valid || m_axis_tready;
  assign process       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(ecc_pkg::TDATA_W - ecc_pkg::RES_W)'(0), res_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= ecc_pkg::item_t'(s_axis_tdata[ecc_pkg::ITEM_W-1:0]);
    end
  end

  ecc_core #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (process),
    .item (item_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (process) begin
      res_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_idle_when_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_q.pending |-> !res_q.moving)
    else $error("Car reported running with no call pending.");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("Stalled input item was dropped.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    process |=> out_valid)
    else $error("Processed item produced no result.");
`endif

endmodule

>>> tb/sv/elevator_collective_controller_unit_tb.sv
module elevator_collective_controller_unit_tb;
  import ecc_pkg::*;

  localparam int FLOORS = 4;
  localparam int TOP = FLOORS - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  item_t request_q[$];
  res_t car_status_q[$];

  logic [FLOORS-1:0] up_req, down_req, cab_req;
  logic [FLOOR_W-1:0] car_pos;
  logic heading_up, running;

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int n_accepted = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int stall_mode = 0;
  int mode_left = 0;

  elevator_collective_controller_unit #(
    .NUM_FLOORS(FLOORS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic res_t advance_car(item_t it);
    logic [FLOORS-1:0] all_c;
    logic f_up, f_down, served;
    int step, i;
    res_t r;
    served = 1'b0;
    step = 0;
    all_c = up_req | down_req | cab_req;
    if (it.cmd == CMD_TICK) begin
      if (all_c != '0) begin
        f_up = 1'b0;
        f_down = 1'b0;
        for (i = 0; i < FLOORS; i++) begin
          if (all_c[i] && i > car_pos) f_up = 1'b1;
          if (all_c[i] && i < car_pos) f_down = 1'b1;
        end
        served = cab_req[car_pos];
        cab_req[car_pos] = 1'b0;
        if (heading_up) begin
          served = served | up_req[car_pos] | (down_req[car_pos] & ~f_up);
          up_req[car_pos] = 1'b0;
        end else begin
          served = served | down_req[car_pos] | (up_req[car_pos] & ~f_down);
          down_req[car_pos] = 1'b0;
        end
        running = 1'b1;
        if (!served) begin
          if (heading_up && !f_up) heading_up = 1'b0;
          else if (!heading_up && !f_down) heading_up = 1'b1;
          step = heading_up ? 1 : -1;
        end else begin
          heading_up = heading_up ? f_up : ~f_down;
          if (car_pos == 0) heading_up = 1'b1;
          if (car_pos == TOP) heading_up = 1'b0;
          if (cab_req[car_pos] || (up_req[car_pos] && heading_up) ||
              (down_req[car_pos] && !heading_up)) begin
            step = 0;
            if (heading_up) up_req[car_pos] = 1'b0;
            else down_req[car_pos] = 1'b0;
          end else if (heading_up) begin
            step = f_up ? 1 : 0;
          end else begin
            step = f_down ? -1 : 0;
          end
          if (!f_up && !f_down &&
              !(up_req[car_pos] | down_req[car_pos] | cab_req[car_pos])) running = 1'b0;
        end
        if (step > 0 && car_pos < TOP) car_pos = car_pos + 1'b1;
        else if (step < 0 && car_pos > 0) car_pos = car_pos - 1'b1;
      end
    end else if (it.cmd == CMD_OPEN) begin
      if (!running) cab_req[car_pos] = 1'b1;
    end else if (it.cmd == CMD_UP || it.cmd == CMD_DOWN || it.cmd == CMD_CAR) begin
      if (it.cmd == CMD_UP) up_req[it.call_floor] = 1'b1;
      else if (it.cmd == CMD_DOWN) down_req[it.call_floor] = 1'b1;
      else cab_req[it.call_floor] = 1'b1;
      if (all_c == '0 && it.call_floor != car_pos) heading_up = it.call_floor > car_pos;
    end
    r.car_floor = car_pos;
    r.going_up = heading_up;
    r.moving = running;
    r.door_open = served;
    r.pending = |(up_req | down_req | cab_req);
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic add_request(logic [CMD_W-1:0] cmd, logic [FLOOR_W-1:0] fl);
    item_t it;
    it.cmd = cmd;
    it.call_floor = fl;
    request_q.push_back(it);
  endtask

  task automatic add_random(int n);
    int k, pick;
    logic [CMD_W-1:0] cmd;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_TICK;
      else if (pick < 60) cmd = CMD_UP;
      else if (pick < 75) cmd = CMD_DOWN;
      else if (pick < 87) cmd = CMD_CAR;
      else if (pick < 93) cmd = CMD_OPEN;
      else if (pick < 97) cmd = CMD_CLOSE;
      else cmd = pick[0] ? CMD_RSVD7 : CMD_RSVD6;
      add_request(cmd, FLOOR_W'($urandom_range(0, TOP)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || car_status_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
      up_req <= '0;
      down_req <= '0;
      cab_req <= '0;
      car_pos <= 2'd1;
      heading_up <= 1'b1;
      running <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        car_status_q.push_back(advance_car(item_t'(s_axis_tdata[ITEM_W-1:0])));
        n_accepted <= n_accepted + 1;
      end
      if (gap_left != 0 || request_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(8 - ITEM_W){1'b0}}, request_q.pop_front()};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[RES_W-1:0]);
        if (car_status_q.size() == 0) begin
          $error("result transfer with no expectation: tdata %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = car_status_q.pop_front();
          check_field("car_floor", want.car_floor, got.car_floor);
          check_field("going_up", want.going_up, got.going_up);
          check_field("moving", want.moving, got.moving);
          check_field("door_open", want.door_open, got.door_open);
          check_field("pending", want.pending, got.pending);
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 250);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (stall_mode == 0) begin
        m_axis_tready <= 1'b1;
      end else if (stall_mode == 1) begin
        m_axis_tready <= ($urandom_range(0, 99) >= 30);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 70);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL elevator_collective_controller_unit");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    add_request(CMD_TICK, 2'd3);
    add_request(CMD_CLOSE, 2'd3);
    add_request(CMD_RSVD6, 2'd2);
    add_request(CMD_RSVD7, 2'd1);
    add_request(CMD_OPEN, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_UP, 2'd3);
    add_request(CMD_TICK, 2'd1);
    add_request(CMD_OPEN, 2'd2);
    add_request(CMD_TICK, 2'd2);
    add_request(CMD_DOWN, 2'd0);
    add_request(CMD_TICK, 2'd3);
    add_request(CMD_CAR, 2'd0);
    add_request(CMD_UP, 2'd0);
    add_request(CMD_DOWN, 2'd3);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_CAR, 2'd2);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    add_request(CMD_TICK, 2'd0);
    wait_drained();
    add_random(600);
    wait_drained();
    add_random(600);
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS elevator_collective_controller_unit");
    end else begin
      $display("FAIL elevator_collective_controller_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ecc_pkg.sv
design/ecc_core.sv
design/elevator_collective_controller_unit.sv
tb/sv/elevator_collective_controller_unit_tb.sv
